>>> rtl/rta_pkg.sv
// Shared types and codes for the region table allocator.
// Request, response, table entry and unit output structs, operation, status and unit mode codes.
// No dependencies.
package rta_pkg;

    localparam int ADDR_W = 32;

    typedef logic [1:0] t_op;
    typedef logic [1:0] t_status;
    typedef logic [1:0] t_umode;

    localparam t_op OP_ALLOC   = 2'd0;
    localparam t_op OP_RELEASE = 2'd1;
    localparam t_op OP_CHECK   = 2'd2;

    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_ZERO = 2'd1;
    localparam t_status ST_FULL = 2'd2;
    localparam t_status ST_MISS = 2'd3;

    // Modes of the shared address unit
    localparam t_umode U_SUM     = 2'd0;
    localparam t_umode U_EQ      = 2'd1;
    localparam t_umode U_CONTAIN = 2'd2;

    typedef struct packed {
        t_op                operation;
        logic [ADDR_W-1:0]  request_size;
        logic [ADDR_W-1:0]  query_address;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [ADDR_W-1:0]  region_start;
        logic               legitimate;
    } t_rsp;

    typedef struct packed {
        logic [ADDR_W-1:0]  start;
        logic [ADDR_W-1:0]  length;
    } t_entry;

    typedef struct packed {
        logic               hit;
        logic [ADDR_W-1:0]  sum;
    } t_unit_out;

endpackage

>>> rtl/region_table_allocator.sv
// Region table allocator top level: sequencer, table RAM and shared address unit.
// Depends on rta_pkg, rta_ram and rta_unit.
//
//   Channel   | Ports                         | Transfer when
//   ----------+-------------------------------+-----------------------------
//   request   | start, busy, i_req            | start high and busy low
//   result    | o_valid, o_rsp                | o_valid high (one cycle)
//   config    | i_cfg_we, i_cfg_wdata         | i_cfg_we high
//
// Sequence: allocate answers straight from idle with an empty or full table or a
//   zero size, otherwise through S_ALLOC. Release and check walk the table one
//   entry a cycle through the single read port of the table RAM; release then
//   compacts one entry a cycle through the same port.
// Reset: synchronous, active low; clears the entry count, state, result strobe and pool base.
//   Table contents are not cleared: only entries below the count are read.
// Stalls: the receiver cannot hold results off; busy is the only back-pressure.
module region_table_allocator #(
    parameter int MAX_REGIONS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  rta_pkg::t_req i_req,
    output logic          o_valid,
    output rta_pkg::t_rsp o_rsp,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_wdata
);
    import rta_pkg::*;

    localparam int IW = $clog2(MAX_REGIONS);
    localparam int CW = $clog2(MAX_REGIONS + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ALLOC = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_SHIFT = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [ADDR_W-1:0] r_pool_base;
    t_req              r_req, n_req;
    logic [IW-1:0]     r_idx, n_idx;
    logic              r_valid, n_valid;
    t_rsp              r_rsp, n_rsp;

    logic [CW-1:0]     cnt_last;
    logic [CW-1:0]     idx_w;
    logic [CW-1:0]     idx_next1;
    logic [CW-1:0]     idx_next2;

    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    t_entry            ram_wdata;
    logic [IW-1:0]     ram_raddr;
    t_entry            ram_rdata;

    t_umode            unit_mode;
    t_unit_out         unit_out;

    assign cnt_last  = r_count - CW'(1);
    assign idx_w     = CW'(r_idx);
    assign idx_next1 = idx_w + CW'(1);
    assign idx_next2 = idx_w + CW'(2);

    // Start and length of every region share one RAM word
    rta_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_REGIONS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rta_unit u_unit (
        .i_mode  (unit_mode),
        .i_addr  (r_req.query_address),
        .i_entry (ram_rdata),
        .o_out   (unit_out)
    );

    // Read address runs one entry ahead of the entry under test, so the
    // registered read data lines up with r_idx in scan, and with r_idx + 1
    // in compaction.
    always_comb begin
        unique case (r_state)
            S_IDLE: begin
                if (i_req.operation == OP_ALLOC) begin
                    ram_raddr = IW'(cnt_last);
                end else begin
                    ram_raddr = '0;
                end
            end
            S_SCAN:  ram_raddr = IW'(idx_next1);
            S_SHIFT: ram_raddr = IW'(idx_next2);
            S_ALLOC: ram_raddr = '0;
        endcase
    end

    always_comb begin
        if (r_state == S_ALLOC) begin
            unit_mode = U_SUM;
        end else if (r_req.operation == OP_RELEASE) begin
            unit_mode = U_EQ;
        end else begin
            unit_mode = U_CONTAIN;
        end
    end

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_req     = r_req;
        n_idx     = r_idx;
        n_valid   = 1'b0;
        n_rsp     = r_rsp;
        ram_we    = 1'b0;
        ram_waddr = IW'(r_count);
        ram_wdata = '{start: unit_out.sum, length: r_req.request_size};

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req = i_req;
                    n_idx = '0;
                    n_rsp = '{status: ST_OK, region_start: '0, legitimate: 1'b0};
                    unique case (i_req.operation)
                        OP_ALLOC: begin
                            priority if (i_req.request_size == '0) begin
                                n_rsp.status = ST_ZERO;
                                n_valid      = 1'b1;
                            end else if (r_count == CW'(MAX_REGIONS)) begin
                                n_rsp.status = ST_FULL;
                                n_valid      = 1'b1;
                            end else if (r_count == '0) begin
                                // first region goes at the pool base
                                ram_we             = 1'b1;
                                ram_waddr          = '0;
                                ram_wdata          = '{start: r_pool_base,
                                                       length: i_req.request_size};
                                n_count            = CW'(1);
                                n_rsp.region_start = r_pool_base;
                                n_valid            = 1'b1;
                            end else begin
                                n_state = S_ALLOC;
                            end
                        end
                        OP_RELEASE: begin
                            if (r_count == '0) begin
                                n_rsp.status = ST_MISS;
                                n_valid      = 1'b1;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_CHECK: begin
                            if (r_count == '0) begin
                                n_valid = 1'b1;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            // unused code: answer with all fields clear
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end

            S_ALLOC: begin
                // newest entry is on the read port: place after it
                ram_we             = 1'b1;
                n_count            = r_count + CW'(1);
                n_rsp.region_start = unit_out.sum;
                n_valid            = 1'b1;
                n_state            = S_IDLE;
            end

            S_SCAN: begin
                if (unit_out.hit) begin
                    if (r_req.operation == OP_RELEASE) begin
                        if (idx_next1 == r_count) begin
                            // removed entry was the newest: nothing to move
                            n_count = cnt_last;
                            n_valid = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_SHIFT;
                        end
                    end else begin
                        n_rsp.legitimate = 1'b1;
                        n_valid          = 1'b1;
                        n_state          = S_IDLE;
                    end
                end else if (idx_next1 == r_count) begin
                    if (r_req.operation == OP_RELEASE) begin
                        n_rsp.status = ST_MISS;
                    end
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_idx = IW'(idx_next1);
                end
            end

            S_SHIFT: begin
                // move entry r_idx + 1 down into r_idx
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = ram_rdata;
                if (idx_next2 == r_count) begin
                    n_count = cnt_last;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_idx = IW'(idx_next1);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_valid     <= 1'b0;
            r_pool_base <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_pool_base <= i_cfg_wdata;
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_idx <= n_idx;
        r_rsp <= n_rsp;
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    // Checks on the sequencer
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_REGIONS))
        else $error("entry count beyond table depth");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_valid || busy))
        else $error("accepted request neither answered nor in progress");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while sequencer busy");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_count)) |-> o_valid)
        else $error("entry count changed without a result");

    a_shift_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_req.operation == OP_RELEASE))
        else $error("compaction outside a release");

endmodule

>>> rtl/rta_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module rta_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/rta_unit.sv
// Shared address unit: one 32-bit adder with an equality and a less-than compare.
// Forms start plus length, or the offset of an address from a region start
// tested for equality or for lying below the length. Depends on rta_pkg.
module rta_unit (
    input  rta_pkg::t_umode    i_mode,
    input  logic [31:0]        i_addr,
    input  rta_pkg::t_entry    i_entry,
    output rta_pkg::t_unit_out o_out
);
    import rta_pkg::*;

    logic [ADDR_W-1:0] op_a;
    logic [ADDR_W-1:0] op_b;
    logic [ADDR_W-1:0] carry_in;
    logic [ADDR_W-1:0] sum;

    always_comb begin
        unique case (i_mode)
            U_SUM: begin
                op_a     = i_entry.start;
                op_b     = i_entry.length;
                carry_in = '0;
            end
            default: begin
                // subtract: addr - start, wrapping modulo 2^32
                op_a     = i_addr;
                op_b     = ~i_entry.start;
                carry_in = ADDR_W'(1);
            end
        endcase
    end

    assign sum = op_a + op_b + carry_in;

    always_comb begin
        o_out.sum = sum;
        if (i_mode == U_EQ) begin
            o_out.hit = (sum == '0);
        end else begin
            o_out.hit = (sum < i_entry.length);
        end
    end

endmodule
